@@ src/chpd_pkg.sv @@
// shared types, constants and lookup tables for the hotplug decision block
package chpd_pkg;

    localparam int FRAC_BITS_DEF = 11;
    localparam int MAX_CORES_DEF = 4;

    localparam int TIME_W  = 32;
    localparam int AVG_W   = 20;
    localparam int RUN_W   = 16;
    localparam int CNT_W   = 3;
    localparam int GATE_W  = 16;
    localparam int DIV_W   = 5;
    localparam int DEC_W   = 2;
    localparam int TH_W    = 5;
    localparam int DWELL_W = 8;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // input tdata layout, lowest bit first
    localparam int IN_NOW_LSB    = 0;
    localparam int IN_AVG_LSB    = IN_NOW_LSB + TIME_W;
    localparam int IN_RUN_LSB    = IN_AVG_LSB + AVG_W;
    localparam int IN_ONLINE_LSB = IN_RUN_LSB + RUN_W;
    localparam int IN_BITS       = IN_ONLINE_LSB + CNT_W;
    localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS      = DEC_W + CNT_W;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // threshold shifts for the normal and power-saving rows
    localparam int SHIFT_NORMAL = 4;
    localparam int SHIFT_SAVING = 1;

    localparam logic [TH_W-1:0] SAVING_ROW_TH = TH_W'(5);

    localparam logic [CNT_W-1:0]  CORE_LIMIT_RST = CNT_W'(4);
    localparam logic [GATE_W-1:0] BOOT_GATE_RST  = '0;
    localparam logic [DIV_W-1:0]  HYST_DIV_RST   = DIV_W'(2);

    typedef enum logic [1:0] {
        REG_CORE_LIMIT = 2'd0,
        REG_BOOT_GATE  = 2'd1,
        REG_HYST_DIV   = 2'd2
    } reg_idx_t;

    typedef enum logic [DEC_W-1:0] {
        DEC_IDLE = 2'd0,
        DEC_DOWN = 2'd1,
        DEC_UP   = 2'd2
    } decision_t;

    typedef struct packed {
        logic [CNT_W-1:0]  core_limit;
        logic [GATE_W-1:0] boot_gate_ms;
        logic [DIV_W-1:0]  hyst_div;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic accum;
        logic step;
        logic decide;
    } cmd_t;

    typedef struct packed {
        logic gated;
        logic walk_done;
        logic out_free;
    } status_t;

    function automatic logic [TH_W-1:0] normal_row(input logic [1:0] idx);
        logic [TH_W-1:0] v;
        case (idx)
            2'd0:    v = TH_W'(5);
            2'd1:    v = TH_W'(6);
            2'd2:    v = TH_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

    // 16 / div with zero treated as one
    function automatic logic [TH_W-1:0] hyst_normal(input logic [DIV_W-1:0] d);
        logic [TH_W-1:0] v;
        case (d) inside
            5'd0, 5'd1:    v = TH_W'(16);
            5'd2:          v = TH_W'(8);
            5'd3:          v = TH_W'(5);
            5'd4:          v = TH_W'(4);
            5'd5:          v = TH_W'(3);
            [5'd6:5'd8]:   v = TH_W'(2);
            [5'd9:5'd16]:  v = TH_W'(1);
            default:       v = '0;
        endcase
        return v;
    endfunction

    // 2 / div with zero treated as one
    function automatic logic [TH_W-1:0] hyst_saving(input logic [DIV_W-1:0] d);
        logic [TH_W-1:0] v;
        case (d) inside
            5'd0, 5'd1: v = TH_W'(2);
            5'd2:       v = TH_W'(1);
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [TH_W-1:0] run_thresh(input logic [2:0] idx);
        logic [TH_W-1:0] v;
        case (idx)
            3'd0:    v = TH_W'(12);
            3'd1:    v = TH_W'(0);
            3'd2:    v = TH_W'(19);
            3'd3:    v = TH_W'(11);
            3'd4:    v = TH_W'(19);
            3'd5:    v = TH_W'(10);
            3'd6:    v = TH_W'(0);
            3'd7:    v = TH_W'(19);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [DWELL_W-1:0] dwell_thresh(input logic [2:0] idx);
        logic [DWELL_W-1:0] v;
        case (idx)
            3'd0:    v = DWELL_W'(140);
            3'd1:    v = DWELL_W'(0);
            3'd2:    v = DWELL_W'(140);
            3'd3:    v = DWELL_W'(190);
            3'd4:    v = DWELL_W'(140);
            3'd5:    v = DWELL_W'(190);
            3'd6:    v = DWELL_W'(0);
            3'd7:    v = DWELL_W'(190);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ src/chpd_regs.sv @@
// configuration register file behind the apb port
module chpd_regs
    import chpd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_CORE_LIMIT: cfg_next.core_limit   = pwdata[CNT_W-1:0];
                REG_BOOT_GATE:  cfg_next.boot_gate_ms = pwdata[GATE_W-1:0];
                REG_HYST_DIV:   cfg_next.hyst_div     = pwdata[DIV_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.core_limit   <= CORE_LIMIT_RST;
            cfg_reg.boot_gate_ms <= BOOT_GATE_RST;
            cfg_reg.hyst_div     <= HYST_DIV_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_sel)
            REG_CORE_LIMIT: prdata = PDATA_W'(cfg_reg.core_limit);
            REG_BOOT_GATE:  prdata = PDATA_W'(cfg_reg.boot_gate_ms);
            REG_HYST_DIV:   prdata = PDATA_W'(cfg_reg.hyst_div);
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ src/chpd_dpath.sv @@
// datapath: sample registers, threshold walk, dwell accumulator and result register
module chpd_dpath
    import chpd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_CORES = MAX_CORES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int SH_NORMAL = FRAC_BITS - SHIFT_NORMAL;
    localparam int SH_SAVING = FRAC_BITS - SHIFT_SAVING;
    localparam int TSH_W     = TH_W + SH_SAVING;
    localparam int CMP_W     = (TSH_W > AVG_W) ? TSH_W : AVG_W;

    localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_CORES);
    localparam logic [CNT_W-1:0] CNT_NORMAL = CNT_W'(MAX_CORES);
    localparam logic [CNT_W-1:0] CNT_SAVING = CNT_W'((MAX_CORES < 2) ? MAX_CORES : 2);

    // sample
    logic [TIME_W-1:0] now_reg;
    logic [AVG_W-1:0]  avg_reg;
    logic [RUN_W-1:0]  run_reg;
    logic [CNT_W-1:0]  online_reg;
    logic              lp_reg;

    // per-item work
    logic              gated_reg;
    logic [TH_W-1:0]   hyst_reg;
    logic [CNT_W-1:0]  n_reg;

    // state kept between items
    logic [CNT_W-1:0]  last_req_reg;
    logic [CNT_W-1:0]  last_req_next;
    logic [TIME_W-1:0] acc_reg;
    logic [TIME_W-1:0] acc_next;
    logic [TIME_W-1:0] prev_reg;
    logic              first_reg;

    // result
    logic              out_valid_reg;
    logic              out_valid_next;
    decision_t         out_dec_reg;
    logic [CNT_W-1:0]  out_req_reg;

    logic              gate_hit;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W:0]   acc_sum;
    logic [TIME_W-1:0] acc_sat;

    logic [CNT_W-1:0]  count;
    logic [TH_W-1:0]   row_val;
    logic [TH_W-1:0]   th;
    logic [CMP_W-1:0]  th_sh;
    logic              below;
    logic              walk_done;

    logic [1:0]        row_m1;
    logic [TH_W-1:0]   up_run;
    logic [TH_W-1:0]   dn_run;
    logic [DWELL_W-1:0] up_dwell;
    logic [DWELL_W-1:0] dn_dwell;
    decision_t         dec_next;
    logic              acc_clear;

    // ---- accumulate stage ----
    assign gate_hit = now_reg <= TIME_W'(cfg.boot_gate_ms);
    assign elapsed  = first_reg ? '0 : (now_reg - prev_reg);
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, elapsed};
    assign acc_sat  = acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];

    // ---- threshold walk, one row entry per cycle ----
    assign count   = lp_reg ? CNT_SAVING : CNT_NORMAL;
    assign row_val = lp_reg ? SAVING_ROW_TH : normal_row(2'(n_reg - CNT_W'(1)));
    assign th      = row_val + ((last_req_reg <= n_reg) ? hyst_reg : TH_W'(0));
    assign th_sh   = CMP_W'(th) << (lp_reg ? SH_SAVING : SH_NORMAL);
    assign below   = CMP_W'(avg_reg) <= th_sh;
    assign walk_done = (n_reg >= count) || below;

    // ---- decision ----
    assign row_m1   = (online_reg > MAX_CNT) ? 2'(MAX_CNT - CNT_W'(1))
                                             : 2'(online_reg - CNT_W'(1));
    assign up_run   = run_thresh({row_m1, 1'b0});
    assign dn_run   = run_thresh({row_m1, 1'b1});
    assign up_dwell = dwell_thresh({row_m1, 1'b0});
    assign dn_dwell = dwell_thresh({row_m1, 1'b1});

    always_comb begin
        dec_next  = DEC_IDLE;
        acc_clear = 1'b0;
        if (online_reg != '0) begin
            if (online_reg < cfg.core_limit && run_reg >= RUN_W'(up_run)) begin
                if (acc_reg >= TIME_W'(up_dwell) && online_reg < n_reg) begin
                    dec_next = DEC_UP;
                end
            end else if (online_reg > CNT_W'(1) && run_reg <= RUN_W'(dn_run)) begin
                if (acc_reg >= TIME_W'(dn_dwell) && online_reg > n_reg) begin
                    dec_next = DEC_DOWN;
                end
            end else begin
                acc_clear = 1'b1;
            end
        end else begin
            acc_clear = 1'b1;
        end
    end

    always_comb begin
        acc_next      = acc_reg;
        last_req_next = last_req_reg;
        if (cmd.accum && !gate_hit) begin
            acc_next = acc_sat;
        end
        if (cmd.decide && !gated_reg) begin
            last_req_next = n_reg;
            if (acc_clear || dec_next != DEC_IDLE) begin
                acc_next = '0;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.decide) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_req_reg  <= '0;
            acc_reg       <= '0;
            prev_reg      <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            gated_reg     <= 1'b0;
            n_reg         <= CNT_W'(1);
        end else begin
            last_req_reg  <= last_req_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load) begin
                n_reg <= CNT_W'(1);
            end else if (cmd.step && !walk_done) begin
                n_reg <= n_reg + CNT_W'(1);
            end
            if (cmd.accum) begin
                gated_reg <= gate_hit;
                if (!gate_hit) begin
                    prev_reg  <= now_reg;
                    first_reg <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg    <= s_tdata[IN_NOW_LSB +: TIME_W];
            avg_reg    <= s_tdata[IN_AVG_LSB +: AVG_W];
            run_reg    <= s_tdata[IN_RUN_LSB +: RUN_W];
            online_reg <= s_tdata[IN_ONLINE_LSB +: CNT_W];
            lp_reg     <= s_tuser;
        end
        if (cmd.accum) begin
            hyst_reg <= lp_reg ? hyst_saving(cfg.hyst_div) : hyst_normal(cfg.hyst_div);
        end
        if (cmd.decide) begin
            out_dec_reg <= gated_reg ? DEC_IDLE : dec_next;
            out_req_reg <= gated_reg ? '0 : n_reg;
        end
    end

    assign status.gated     = gated_reg;
    assign status.walk_done = walk_done;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_req_reg, out_dec_reg});

    // any up or down decision leaves the dwell timer cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide && !gated_reg && dec_next != DEC_IDLE |=> acc_reg == '0)
        else $error("dwell accumulator not cleared after a core change");

    // a gated item reports idle and zero cores
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide && gated_reg |=> out_dec_reg == DEC_IDLE && out_req_reg == '0)
        else $error("gated item produced a non-idle result");

    // the walk never runs past the end of the selected row
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> n_reg <= count)
        else $error("threshold walk ran past its row");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_req_reg <= MAX_CNT)
        else $error("required core count above the core maximum");

endmodule

@@ src/chpd_ctrl.sv @@
// controller: sequences load, accumulate, threshold walk and decision for each item
module chpd_ctrl
    import chpd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ACCUM  = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd.load   = s_tvalid && s_tready;
        cmd.accum  = (state_reg == ST_ACCUM);
        cmd.step   = (state_reg == ST_WALK);
        cmd.decide = (state_reg == ST_DECIDE) && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (status.gated || status.walk_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/core_hotplug_decision.sv @@
// top level of the run-queue core hotplug decision block
// Each accepted sample yields exactly one result item. After acceptance the
// item goes through the accumulate step, then walks the threshold row (one
// row entry per cycle, stopping at the first entry the average queue length
// does not exceed, with a closing step when no entry holds it), and then the
// decision step; a new sample is accepted only once the current item has been
// decided. The result sits in an output register and the block returns to
// accept the next item as soon as that register is free.
// Samples at or before the boot gate report idle with zero required cores and
// leave the state kept between items untouched. Configuration is written
// through the apb port; the user must write it only while idle, and the
// block itself does not enforce this.
module core_hotplug_decision
    import chpd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_CORES = MAX_CORES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // apb configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready,
    // sample input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // now_ms, avg_queue_fixed, running_figure, cores_online
    input  logic                   s_tuser,  // low_power
    // decision output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata   // decision, cores_required
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    chpd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    chpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    chpd_dpath #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_CORES (MAX_CORES)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
